@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers, removed from synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge out of reset
`define AST_PROP(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Check that a condition never holds out of reset
`define AST_NEVER(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define AST_PROP(name, clk, rst_n, prop)
`define AST_NEVER(name, clk, rst_n, cond)

`endif

`endif

@@ hdl/crsfr_pkg.sv @@
// ----------------------------------------------------------------------------
// crsfr_pkg
// Shared constants and types of the serial frame receiver.
// ----------------------------------------------------------------------------
package crsfr_pkg;

	// Default sizing
	localparam int unsigned CHANNEL_COUNT_DEF = 16;
	localparam int unsigned MAX_LENGTH_DEF    = 62;

	// Frame format
	localparam logic [7:0] SYNC_BYTE     = 8'hC8;
	localparam logic [7:0] LEN_MIN       = 8'd2;
	localparam logic [7:0] TYPE_CHANNELS = 8'h16;
	localparam logic [7:0] TYPE_LINK     = 8'h14;
	localparam logic [7:0] CRC_POLY      = 8'hD5;

	localparam int unsigned CHANNEL_PAYLOAD = 22;
	localparam int unsigned LINK_PAYLOAD    = 10;

	// Byte counter covers sync, length and up to MAX_LENGTH more bytes
	localparam int unsigned FILL_W = 7;

	// Frame totals (sync + length + type + payload + crc)
	localparam logic [FILL_W-1:0] CHAN_TOTAL = FILL_W'(CHANNEL_PAYLOAD + 4);
	localparam logic [FILL_W-1:0] LINK_TOTAL = FILL_W'(LINK_PAYLOAD + 4);

	// Type and payload byte positions within the frame
	localparam logic [FILL_W-1:0] PAY_FIRST = FILL_W'(3);
	localparam logic [FILL_W-1:0] PAY_LAST  = FILL_W'(CHANNEL_PAYLOAD + 2);
	localparam logic [FILL_W-1:0] POS_TYPE  = FILL_W'(2);
	localparam logic [FILL_W-1:0] POS_RSSI0 = FILL_W'(3);
	localparam logic [FILL_W-1:0] POS_RSSI1 = FILL_W'(4);
	localparam logic [FILL_W-1:0] POS_LQ    = FILL_W'(5);

	// Channel values
	localparam int unsigned CH_W          = 11;
	localparam logic [CH_W-1:0] CHANNEL_RESET = 11'd992;
	localparam logic [6:0] QUALITY_CAP   = 7'd100;

	// Event queue between parser and result sequencer
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		KIND_IGNORED  = 2'd0,
		KIND_CRC_ERR  = 2'd1,
		KIND_CHANNELS = 2'd2,
		KIND_LINK     = 2'd3
	} kind_t;

	// One finished frame, as seen by the result sequencer
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  rssi;
		logic [6:0]  quality;
	} evt_t;

	// One result word
	typedef struct packed {
		kind_t              kind;
		logic               last;
		logic [3:0]         channel_index;
		logic [CH_W-1:0]    channel_value;
		logic signed [7:0]  rssi_level;
		logic [6:0]         link_quality;
		logic               link_seen;
		logic [31:0]        crc_errors;
		logic [31:0]        channel_frames;
	} res_t;

endpackage

@@ hdl/crsfr_front.sv @@
// ----------------------------------------------------------------------------
// crsfr_front
// Byte parser: sync hunt, length check, running CRC, channel unpacking and
// frame classification. Pushes one event per finished frame.
// ----------------------------------------------------------------------------
module crsfr_front import crsfr_pkg::*; #(
	parameter int unsigned CHANNEL_COUNT = CHANNEL_COUNT_DEF,
	parameter int unsigned MAX_LENGTH    = MAX_LENGTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    in_byte,
	input  logic                          q_full,
	output logic                          push,
	output evt_t                          evt,
	output logic [CHANNEL_COUNT*CH_W-1:0] chans
);

	localparam int unsigned CIDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	localparam int unsigned CCNT_W = $clog2(CHANNEL_COUNT + 1);

	logic [FILL_W-1:0]  fill_q;
	logic [FILL_W-1:0]  total_q;
	logic [7:0]         crc_q;
	logic [7:0]         type_q;
	logic [7:0]         lb0_q;
	logic [7:0]         lb1_q;
	logic [7:0]         lb2_q;
	logic [17:0]        acc_q;
	logic [4:0]         nbits_q;
	logic [CCNT_W-1:0]  chcnt_q;
	logic [CH_W-1:0]    ch_q [CHANNEL_COUNT];

	logic               accept;
	logic               last_byte;
	logic               unpack_en;
	logic [17:0]        acc_in;
	logic [4:0]         nb_in;
	logic               ch_done;
	logic [7:0]         best;

	// Shift one byte through the CRC register, MSB first
	function automatic logic [7:0] crc_step(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		for (int b = 0; b < 8; b++) begin
			r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		end
		return r;
	endfunction

	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;
	assign last_byte = (fill_q + FILL_W'(1)) == total_q;

	// Append the byte to the bit accumulator
	assign acc_in    = acc_q | (18'(in_byte) << nbits_q);
	assign nb_in     = nbits_q + 5'd8;
	assign ch_done   = nb_in >= 5'(CH_W);
	assign unpack_en = (fill_q >= PAY_FIRST) && (fill_q <= PAY_LAST)
		&& (chcnt_q < CCNT_W'(CHANNEL_COUNT));

	// Classify the frame on its crc byte
	assign best = (lb0_q < lb1_q) ? lb0_q : lb1_q;
	assign push = accept && (fill_q >= POS_TYPE) && last_byte;

	always_comb begin
		evt.rssi    = 8'(8'd0 - best);
		evt.quality = (lb2_q > 8'(QUALITY_CAP)) ? QUALITY_CAP : lb2_q[6:0];
		if (crc_q != in_byte) begin
			evt.kind = KIND_CRC_ERR;
		end else if (type_q == TYPE_CHANNELS && total_q == CHAN_TOTAL) begin
			evt.kind = KIND_CHANNELS;
		end else if (type_q == TYPE_LINK && total_q == LINK_TOTAL) begin
			evt.kind = KIND_LINK;
		end else begin
			evt.kind = KIND_IGNORED;
		end
	end

	for (genvar i = 0; i < CHANNEL_COUNT; i++) begin : g_flat
		assign chans[i*CH_W +: CH_W] = ch_q[i];
	end

	// Parser control and running CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			total_q <= '0;
			crc_q   <= '0;
			acc_q   <= '0;
			nbits_q <= '0;
			chcnt_q <= '0;
		end else if (accept) begin
			if (fill_q == '0) begin
				if (in_byte == SYNC_BYTE) begin
					fill_q <= FILL_W'(1);
				end
			end else if (fill_q == FILL_W'(1)) begin
				if (in_byte < LEN_MIN || in_byte > 8'(MAX_LENGTH)) begin
					fill_q  <= (in_byte == SYNC_BYTE) ? FILL_W'(1) : '0;
					total_q <= '0;
				end else begin
					fill_q  <= FILL_W'(2);
					total_q <= FILL_W'(in_byte) + FILL_W'(2);
					crc_q   <= '0;
					acc_q   <= '0;
					nbits_q <= '0;
					chcnt_q <= '0;
				end
			end else if (last_byte) begin
				fill_q  <= '0;
				total_q <= '0;
			end else begin
				fill_q <= fill_q + FILL_W'(1);
				crc_q  <= crc_step(crc_q ^ in_byte);
				if (unpack_en) begin
					if (ch_done) begin
						acc_q   <= acc_in >> CH_W;
						nbits_q <= nb_in - 5'(CH_W);
						chcnt_q <= chcnt_q + CCNT_W'(1);
					end else begin
						acc_q   <= acc_in;
						nbits_q <= nb_in;
					end
				end
			end
		end
	end

	// Capture type, link bytes and decoded channels
	always_ff @(posedge clk) begin
		if (accept && fill_q >= POS_TYPE && !last_byte) begin
			if (fill_q == POS_TYPE)  type_q <= in_byte;
			if (fill_q == POS_RSSI0) lb0_q  <= in_byte;
			if (fill_q == POS_RSSI1) lb1_q  <= in_byte;
			if (fill_q == POS_LQ)    lb2_q  <= in_byte;
			if (unpack_en && ch_done) begin
				ch_q[chcnt_q[CIDX_W-1:0]] <= acc_in[CH_W-1:0];
			end
		end
	end

endmodule

@@ hdl/crsfr_fifo.sv @@
// ----------------------------------------------------------------------------
// crsfr_fifo
// Short register queue that decouples the parser from the result sequencer.
// ----------------------------------------------------------------------------
module crsfr_fifo import crsfr_pkg::*; #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full    = count_q == CW'(DEPTH);
	assign empty   = count_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ hdl/crsfr_back.sv @@
// ----------------------------------------------------------------------------
// crsfr_back
// Result sequencer: pops frame events, updates counters and link values,
// and emits one result word per cycle while out_ready allows, through an output register.
// ----------------------------------------------------------------------------
module crsfr_back import crsfr_pkg::*; #(
	parameter int unsigned CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  evt_t                          q_evt,
	input  logic [CHANNEL_COUNT*CH_W-1:0] q_chans,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output res_t                          res
);

	localparam int unsigned CIDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

	logic              busy_q;
	logic [CIDX_W-1:0] pos_q;
	logic [CH_W-1:0]   chan_q [CHANNEL_COUNT];
	logic [31:0]       crc_tot_q;
	logic [31:0]       chf_tot_q;
	logic [7:0]        rssi_q;
	logic [6:0]        lq_q;
	logic              seen_q;
	logic              o_valid_q;
	kind_t             o_kind_q;
	logic              o_last_q;
	logic [3:0]        o_idx_q;
	logic [CH_W-1:0]   o_val_q;

	logic              advance;

	assign advance = !o_valid_q || out_ready;
	assign pop     = advance && !busy_q && !q_empty;

	assign out_valid          = o_valid_q;
	assign res.kind           = o_kind_q;
	assign res.last           = o_last_q;
	assign res.channel_index  = o_idx_q;
	assign res.channel_value  = o_val_q;
	assign res.rssi_level     = rssi_q;
	assign res.link_quality   = lq_q;
	assign res.link_seen      = seen_q;
	assign res.crc_errors     = crc_tot_q;
	assign res.channel_frames = chf_tot_q;

	// Load the next result word whenever the output register frees up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			pos_q     <= '0;
			crc_tot_q <= '0;
			chf_tot_q <= '0;
			rssi_q    <= '0;
			lq_q      <= '0;
			seen_q    <= 1'b0;
			o_valid_q <= 1'b0;
			o_kind_q  <= KIND_IGNORED;
			o_last_q  <= 1'b0;
			o_idx_q   <= '0;
			o_val_q   <= '0;
			for (int i = 0; i < CHANNEL_COUNT; i++) begin
				chan_q[i] <= CHANNEL_RESET;
			end
		end else if (advance) begin
			if (busy_q) begin
				o_valid_q <= 1'b1;
				o_kind_q  <= KIND_CHANNELS;
				o_idx_q   <= 4'(pos_q);
				o_val_q   <= chan_q[pos_q];
				o_last_q  <= pos_q == CIDX_W'(CHANNEL_COUNT - 1);
				busy_q    <= pos_q != CIDX_W'(CHANNEL_COUNT - 1);
				pos_q     <= pos_q + CIDX_W'(1);
			end else if (!q_empty) begin
				o_valid_q <= 1'b1;
				o_kind_q  <= q_evt.kind;
				o_idx_q   <= '0;
				o_val_q   <= '0;
				o_last_q  <= 1'b1;
				unique case (q_evt.kind)
					KIND_CRC_ERR: begin
						crc_tot_q <= crc_tot_q + 32'd1;
					end
					KIND_CHANNELS: begin
						chf_tot_q <= chf_tot_q + 32'd1;
						for (int i = 0; i < CHANNEL_COUNT; i++) begin
							chan_q[i] <= q_chans[i*CH_W +: CH_W];
						end
						o_val_q  <= q_chans[CH_W-1:0];
						o_last_q <= CHANNEL_COUNT == 1;
						busy_q   <= CHANNEL_COUNT > 1;
						pos_q    <= CIDX_W'(1);
					end
					KIND_LINK: begin
						rssi_q <= q_evt.rssi;
						lq_q   <= q_evt.quality;
						seen_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end else begin
				o_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hdl/crsf_frame_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// crsf_frame_receiver_unit
// Serial frame receiver: finds frames, checks CRC-8 (poly 0xD5), decodes
// channel and link-statistics frames and streams out result words.
//
// Channel   Dir  tdata                                   tuser        tlast
// s_axis    in   received byte                           -            -
// m_axis    out  index, value, rssi, lq, seen, counters  result kind  last word of frame
//
// One received byte is taken per cycle while s_axis_tready is high; the first
// result word of a frame goes through the event queue and the output register
// once that register is free. A channel frame gives CHANNEL_COUNT words from the
// result sequencer at one per cycle while m_axis_tready holds, every other frame
// gives one word. s_axis_tready drops only while the two-entry frame event queue
// is full. Reset clears all control state at once; there is no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crsf_frame_receiver_unit import crsfr_pkg::*; #(
	parameter int unsigned CHANNEL_COUNT = CHANNEL_COUNT_DEF,
	parameter int unsigned MAX_LENGTH    = MAX_LENGTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [3:0] channel_index, [14:4] channel_value, [22:15] rssi_level,
	// [29:23] link_quality, [30] link_seen, [62:31] crc_errors,
	// [94:63] channel_frames, [95] zero
	output logic [95:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
	output logic        m_axis_tlast    // last_of_run
);

	localparam int unsigned CHF_W = CHANNEL_COUNT * CH_W;
	localparam int unsigned Q_W   = CHF_W + $bits(evt_t);

	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;
	evt_t             f_evt;
	logic [CHF_W-1:0] f_chans;
	logic [Q_W-1:0]   q_rd;
	evt_t             b_evt;
	logic [CHF_W-1:0] b_chans;
	res_t             res;

	// Parse bytes and classify frames
	crsfr_front #(
		.CHANNEL_COUNT (CHANNEL_COUNT),
		.MAX_LENGTH    (MAX_LENGTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.q_full   (q_full),
		.push     (q_push),
		.evt      (f_evt),
		.chans    (f_chans)
	);

	// Queue finished frames
	crsfr_fifo #(
		.WIDTH (Q_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data ({f_chans, f_evt}),
		.pop     (q_pop),
		.rd_data (q_rd),
		.full    (q_full),
		.empty   (q_empty)
	);

	assign b_evt   = q_rd[$bits(evt_t)-1:0];
	assign b_chans = q_rd[Q_W-1:$bits(evt_t)];

	// Emit result words
	crsfr_back #(
		.CHANNEL_COUNT (CHANNEL_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_evt     (b_evt),
		.q_chans   (b_chans),
		.pop       (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = {1'b0, res.channel_frames, res.crc_errors, res.link_seen,
		res.link_quality, res.rssi_level, res.channel_value, res.channel_index};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;

	// Never write into a full event queue
	`AST_NEVER(a_no_overflow, clk, arst_n, q_push && q_full && !q_pop)

	// Every word that is not a channel value closes its frame
	`AST_PROP(a_single_last, clk, arst_n,
		(m_axis_tvalid && res.kind != KIND_CHANNELS) |-> m_axis_tlast)

	// Error count only moves by one, together with a crc error word
	`AST_PROP(a_crc_step, clk, arst_n,
		(res.crc_errors != $past(res.crc_errors)) |->
		(res.crc_errors == $past(res.crc_errors) + 32'd1 && res.kind == KIND_CRC_ERR))

endmodule

@@ sim/crsf_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsf_result_checker
// Watches both stream channels of the frame receiver. Every accepted byte is
// run through a behavioral frame parser that queues the result words it
// should cause; every accepted result word is compared with the oldest one.
// ----------------------------------------------------------------------------
package crsf_sim_pkg;

	import crsfr_pkg::*;

	typedef logic [7:0] byte_q_t[$];

	// Fold one byte into a CRC-8 DVB-S2 remainder, MSB first
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

module crsf_result_checker import crsfr_pkg::*; import crsf_sim_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [95:0] m_axis_tdata,
	input  logic [1:0]  m_axis_tuser,
	input  logic        m_axis_tlast,
	output int          mismatch_count,
	output int          words_waiting,
	output int          words_checked
);

	// Parser state, mirrors what the receiver must hold
	logic [FILL_W-1:0] bytes_held;
	logic [FILL_W-1:0] frame_total;
	logic [7:0]        frame_buf [64];
	logic [CH_W-1:0]   chan_val [16];
	logic [31:0]       crc_fail_total;
	logic [31:0]       chan_frame_total;
	logic [7:0]        rssi_now;
	logic [6:0]        lq_now;
	logic              link_seen_now;

	res_t expected_words[$];

	// Queue one result word carrying the current link values and counters
	function automatic void queue_word(input kind_t k, input logic lst,
			input logic [3:0] idx, input logic [CH_W-1:0] val);
		res_t w;
		w.kind           = k;
		w.last           = lst;
		w.channel_index  = idx;
		w.channel_value  = val;
		w.rssi_level     = rssi_now;
		w.link_quality   = lq_now;
		w.link_seen      = link_seen_now;
		w.crc_errors     = crc_fail_total;
		w.channel_frames = chan_frame_total;
		expected_words.push_back(w);
	endfunction

	// Advance the frame parser by one received byte
	task automatic absorb_rx_byte(input logic [7:0] b);
		logic [7:0]   len;
		logic [7:0]   crc;
		logic [7:0]   best;
		logic [7:0]   q;
		logic [175:0] pay_bits;
		if (bytes_held == 0) begin
			// hunt for sync, drop anything else
			if (b == SYNC_BYTE) begin
				frame_buf[0] = b;
				bytes_held = 1;
			end
		end else if (bytes_held == 1) begin
			if (b < LEN_MIN || b > MAX_LENGTH_DEF) begin
				// bad length; a sync byte here starts over
				bytes_held = (b == SYNC_BYTE) ? 1 : 0;
				frame_total = '0;
			end else begin
				frame_buf[1] = b;
				bytes_held = 2;
				frame_total = FILL_W'(b) + FILL_W'(2);
			end
		end else begin
			frame_buf[bytes_held[5:0]] = b;
			bytes_held = bytes_held + 1;
			if (bytes_held == frame_total) begin
				len = frame_buf[1];
				crc = '0;
				for (int i = 2; i <= len; i++) begin
					crc = crc8_update(crc, frame_buf[i]);
				end
				if (crc != frame_buf[len + 1]) begin
					crc_fail_total = crc_fail_total + 1;
					queue_word(KIND_CRC_ERR, 1'b1, '0, '0);
				end else if (frame_buf[2] == TYPE_CHANNELS && len == CHANNEL_PAYLOAD + 2) begin
					// unpack 11-bit channels, LSB first
					for (int i = 0; i < CHANNEL_PAYLOAD; i++) begin
						pay_bits[8*i +: 8] = frame_buf[3 + i];
					end
					for (int c = 0; c < CHANNEL_COUNT_DEF; c++) begin
						chan_val[c] = pay_bits[CH_W*c +: CH_W];
					end
					chan_frame_total = chan_frame_total + 1;
					for (int c = 0; c < CHANNEL_COUNT_DEF; c++) begin
						queue_word(KIND_CHANNELS, c == CHANNEL_COUNT_DEF - 1, 4'(c), chan_val[c]);
					end
				end else if (frame_buf[2] == TYPE_LINK && len == LINK_PAYLOAD + 2) begin
					best = (frame_buf[3] < frame_buf[4]) ? frame_buf[3] : frame_buf[4];
					q = frame_buf[5];
					rssi_now = 8'd0 - best;
					lq_now = (q > QUALITY_CAP) ? QUALITY_CAP : q[6:0];
					link_seen_now = 1'b1;
					queue_word(KIND_LINK, 1'b1, '0, '0);
				end else begin
					queue_word(KIND_IGNORED, 1'b1, '0, '0);
				end
				bytes_held = '0;
				frame_total = '0;
			end
		end
	endtask

	// Sample both channels mid-cycle, where every signal has settled
	always @(negedge clk or negedge arst_n) begin : watch
		res_t got;
		res_t want;
		if (!arst_n) begin
			bytes_held = '0;
			frame_total = '0;
			for (int c = 0; c < 16; c++) begin
				chan_val[c] = CHANNEL_RESET;
			end
			crc_fail_total = '0;
			chan_frame_total = '0;
			rssi_now = '0;
			lq_now = '0;
			link_seen_now = 1'b0;
			expected_words.delete();
			mismatch_count = 0;
			words_waiting = 0;
			words_checked = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				absorb_rx_byte(s_axis_tdata);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind           = kind_t'(m_axis_tuser);
				got.last           = m_axis_tlast;
				got.channel_index  = m_axis_tdata[3:0];
				got.channel_value  = m_axis_tdata[14:4];
				got.rssi_level     = m_axis_tdata[22:15];
				got.link_quality   = m_axis_tdata[29:23];
				got.link_seen      = m_axis_tdata[30];
				got.crc_errors     = m_axis_tdata[62:31];
				got.channel_frames = m_axis_tdata[94:63];
				words_checked++;
				if (expected_words.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("[%0t] unexpected result word: kind %0d idx %0d val %0d",
							$realtime, got.kind, got.channel_index, got.channel_value);
					end
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("[%0t] word %0d mismatch (expected/actual):", $realtime,
								words_checked);
							$display("  kind %0d/%0d last %0d/%0d idx %0d/%0d val %0d/%0d",
								want.kind, got.kind, want.last, got.last,
								want.channel_index, got.channel_index,
								want.channel_value, got.channel_value);
							$display("  rssi %0d/%0d lq %0d/%0d seen %0d/%0d",
								want.rssi_level, got.rssi_level, want.link_quality,
								got.link_quality, want.link_seen, got.link_seen);
							$display("  crc_errors %0d/%0d channel_frames %0d/%0d",
								want.crc_errors, got.crc_errors,
								want.channel_frames, got.channel_frames);
						end
					end
				end
			end
			words_waiting = expected_words.size();
		end
	end

endmodule

@@ sim/tb_crsf_frame_receiver_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crsf_frame_receiver_unit
// Feeds the frame receiver a byte stream of channel, link-statistics and other
// frames, corrupted CRCs, bad lengths, cut-off frames and line noise, with
// random gaps on the input and random backpressure on the result stream.
// ----------------------------------------------------------------------------
module tb_crsf_frame_receiver_unit;

	import crsfr_pkg::*;
	import crsf_sim_pkg::*;

	localparam int ITEM_TARGET  = 320;
	localparam int CYCLE_LIMIT  = 4000000;
	localparam int DRAIN_CYCLES = 40;

	typedef enum int {
		FILL_RANDOM,
		FILL_ZERO,
		FILL_ONES
	} fill_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	int mismatch_count;
	int words_waiting;
	int words_checked;

	int tick_count = 0;
	int ready_hold = 0;
	int bytes_sent = 0;
	int noise_bytes = 0;
	int frames_sent = 0;
	bit steady_frame = 1'b0;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	crsf_frame_receiver_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	crsf_result_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tuser   (m_axis_tuser),
		.m_axis_tlast   (m_axis_tlast),
		.mismatch_count (mismatch_count),
		.words_waiting  (words_waiting),
		.words_checked  (words_checked)
	);

	// Abort a hung run
	always @(posedge clk) begin
		tick_count <= tick_count + 1;
		if (tick_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d result words still due", tick_count,
				words_waiting);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Pace the result stream: long ready stretches, short and long stalls
	always @(posedge clk) begin : result_pacing
		int roll;
		if (arst_n) begin
			if (ready_hold > 0) begin
				ready_hold <= ready_hold - 1;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 55) begin
					m_axis_tready <= 1'b1;
					ready_hold <= $urandom_range(0, 30);
				end else if (roll < 90) begin
					m_axis_tready <= 1'b0;
					ready_hold <= $urandom_range(0, 2);
				end else begin
					m_axis_tready <= 1'b0;
					ready_hold <= $urandom_range(15, 80);
				end
			end
		end
	end

	function automatic byte_q_t make_payload(input int n, input fill_t mode);
		byte_q_t q;
		for (int i = 0; i < n; i++) begin
			case (mode)
				FILL_ZERO: q.push_back(8'h00);
				FILL_ONES: q.push_back(8'hFF);
				default:   q.push_back(8'($urandom));
			endcase
		end
		return q;
	endfunction

	// Send one byte after a random gap; return at the edge that takes it
	task automatic send_byte(input logic [7:0] b);
		int gap;
		int roll;
		roll = $urandom_range(0, 99);
		if (steady_frame || roll < 70) begin
			gap = 0;
		end else if (roll < 95) begin
			gap = $urandom_range(1, 3);
		end else begin
			gap = $urandom_range(10, 60);
		end
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		@(negedge clk);
		while (!s_axis_tready) @(negedge clk);
		@(posedge clk);
		bytes_sent++;
	endtask

	// Send sync, length, type, payload and CRC, optionally corrupting the CRC
	task automatic send_frame(input logic [7:0] ftype, input byte_q_t body, input bit bad_crc);
		logic [7:0] crc;
		crc = crc8_update(8'h00, ftype);
		foreach (body[i]) crc = crc8_update(crc, body[i]);
		if (bad_crc) begin
			crc ^= 8'($urandom_range(1, 255));
		end
		frames_sent++;
		send_byte(SYNC_BYTE);
		send_byte(8'(body.size() + 2));
		send_byte(ftype);
		foreach (body[i]) send_byte(body[i]);
		send_byte(crc);
	endtask

	initial begin : stimulus
		byte_q_t    body;
		int         roll;
		int         sel;
		bit         bad;
		logic [7:0] ftype;
		int         plen;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Line noise while hunting for sync
		send_byte(8'h00);
		send_byte(8'hFF);
		// Length below and above the legal range
		send_byte(SYNC_BYTE);
		send_byte(8'h01);
		send_byte(SYNC_BYTE);
		send_byte(8'(MAX_LENGTH_DEF + 1));
		// Sync in the length slot restarts; shortest frame, channel type wrong size
		send_byte(SYNC_BYTE);
		body = {};
		send_frame(TYPE_CHANNELS, body, 1'b0);
		// Shortest frame with a broken CRC
		send_frame(8'hFF, body, 1'b1);
		// Link stats: the lower rssi byte wins, quality over the cap
		body = make_payload(LINK_PAYLOAD, FILL_ZERO);
		body[0] = 8'h80;
		body[1] = 8'hFF;
		body[2] = 8'hFF;
		send_frame(TYPE_LINK, body, 1'b0);

		// Mostly well-formed frames with random content, some damage and noise
		while (bytes_sent - noise_bytes < ITEM_TARGET) begin
			steady_frame = ($urandom_range(0, 99) < 30);
			roll = $urandom_range(0, 99);
			bad = ($urandom_range(0, 99) < 15);
			sel = $urandom_range(0, 9);
			if (roll < 30) begin
				body = make_payload(CHANNEL_PAYLOAD,
					(sel == 0) ? FILL_ZERO : (sel == 1) ? FILL_ONES : FILL_RANDOM);
				send_frame(TYPE_CHANNELS, body, bad);
			end else if (roll < 55) begin
				body = make_payload(LINK_PAYLOAD, FILL_RANDOM);
				if (sel < 3) begin
					body[1] = body[0];
				end
				send_frame(TYPE_LINK, body, bad);
			end else if (roll < 70) begin
				if (sel < 3) begin
					ftype = $urandom_range(0, 1) ? TYPE_CHANNELS : TYPE_LINK;
				end else begin
					ftype = 8'($urandom);
				end
				plen = ($urandom_range(0, 9) == 0) ? MAX_LENGTH_DEF - 2 : $urandom_range(0, 8);
				send_frame(ftype, make_payload(plen, FILL_RANDOM), bad);
			end else if (roll < 80) begin
				// sync followed by an illegal length
				send_byte(SYNC_BYTE);
				if (sel < 3) begin
					send_byte(8'($urandom_range(0, 1)));
				end else if (sel < 5) begin
					send_byte(SYNC_BYTE);
				end else begin
					send_byte(8'($urandom_range(MAX_LENGTH_DEF + 1, 255)));
				end
			end else if (roll < 90) begin
				// cut-off frame; later bytes complete it
				send_byte(SYNC_BYTE);
				send_byte(8'($urandom_range(LEN_MIN, 12)));
				repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
			end else begin
				repeat ($urandom_range(1, 4)) begin
					send_byte(8'($urandom));
					noise_bytes++;
				end
			end
		end
		s_axis_tvalid <= 1'b0;

		// Drain, then watch a while for stray words
		wait (words_waiting == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d bytes (%0d frames, %0d noise bytes), checked %0d result words",
			bytes_sent, frames_sent, noise_bytes, words_checked);
		$display("%0d mismatches, %0d words still due", mismatch_count, words_waiting);
		if (mismatch_count == 0 && words_waiting == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
